// ===== design/rlz_pkg.sv =====
// ---------------------------------------------------------------------------
// rlz_pkg: shared types and constants for the RefPack decompressor
// Holds the command decode constants, the parser phase type and the
// control and status structures between the sequencer and the packer.
// ---------------------------------------------------------------------------
package rlz_pkg;

  // Number of bytes that one result word carries.
  localparam int unsigned RES_BYTES = 32;

  // Header length in bytes, and the bytes holding the stream length.
  localparam logic [3:0] HDR_LEN      = 4'd9;
  localparam logic [3:0] HDR_LEN_END  = 4'd4;
  localparam logic [3:0] HDR_SIZE_BEG = 4'd6;

  // Command byte ranges.
  localparam logic [7:0] CMD_LIT_SHORT = 8'hFC;
  localparam logic [7:0] CMD_LIT_LONG  = 8'hE0;
  localparam logic [7:0] CMD_FORM_TWO  = 8'h80;
  localparam logic [7:0] CMD_FORM_FOUR = 8'hC0;
  localparam logic [4:0] LIT_LONG_MASK = 5'h1F;
  localparam logic [10:0] FAR_LEN_BIAS = 11'h005;

  // Saturation value of the consumed byte counter.
  localparam logic [31:0] CONSUMED_MAX = 32'hFFFF_FFFF;

  // Parser phase: command awaited, command bytes still due, literals due.
  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_ONE   = 3'd1,
    PH_TWO   = 3'd2,
    PH_THREE = 3'd3,
    PH_LIT   = 3'd4
  } phase_t;

  // Requests from the sequencer to the packer.
  typedef struct packed {
    logic push;
    logic flush;
    logic last;
    logic bad;
    logic done;
  } pk_ctrl_t;

  // Packer status seen by the sequencer.
  typedef struct packed {
    logic full;
    logic out_free;
  } pk_stat_t;

endpackage

// ===== design/rlz_hist_mem.sv =====
// ---------------------------------------------------------------------------
// rlz_hist_mem: history memory of the decompressor
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module rlz_hist_mem #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rlz_packer.sv =====
// ---------------------------------------------------------------------------
// rlz_packer: gathers output bytes into 32-byte result words
// Bytes are pushed one at a time; a flush moves the gathered word to the
// output register, which parts the sequencer from the receiver.
// ---------------------------------------------------------------------------
module rlz_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  rlz_pkg::pk_ctrl_t ctrl,
  input  logic [7:0]        push_byte,
  output rlz_pkg::pk_stat_t stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [263:0]      out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  logic [255:0] hold_r;
  logic [5:0]   cnt_r;
  logic         ov_r;
  logic [255:0] obytes_r;
  logic [5:0]   ocnt_r;
  logic         olast_r;
  logic         obad_r;
  logic         odone_r;

  assign stat.full     = (cnt_r == 6'(rlz_pkg::RES_BYTES));
  assign stat.out_free = !ov_r || out_tready;

  // Gathering register and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ctrl.flush) begin
        hold_r <= '0;
        cnt_r  <= '0;
        ov_r   <= 1'b1;
      end else begin
        if (out_tready) begin
          ov_r <= 1'b0;
        end
        if (ctrl.push) begin
          hold_r[{cnt_r[4:0], 3'b000} +: 8] <= push_byte;
          cnt_r <= cnt_r + 6'd1;
        end
      end
    end
  end

  // Output payload, loaded on a flush.
  always_ff @(posedge clk) begin
    if (ctrl.flush) begin
      obytes_r <= hold_r;
      ocnt_r   <= cnt_r;
      olast_r  <= ctrl.last;
      obad_r   <= ctrl.bad;
      odone_r  <= ctrl.done;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ocnt_r, obytes_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = {obad_r, odone_r};

endmodule

// ===== design/refpack_lz_decompressor.sv =====
// ---------------------------------------------------------------------------
// refpack_lz_decompressor: RefPack (QFS) LZ77 stream decompressor
// Parses the header and commands, copies back references through a
// history memory and sends the produced bytes in 32-byte result words.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel takes one compressed byte per word; tuser set marks
//   the first byte of a new stream and restarts the header parser.
//   The output channel gives up to 32 bytes per word with a byte count;
//   tlast ends the words caused by one input byte, tuser carries the
//   stream done and bad reference flags.
//   An input word is taken only when the previous one is fully handled.
//   A back reference is copied one byte at a time, as each copied byte
//   needs a read of the history memory and then a write of the new byte.
//   Each full 32-byte word and the closing word also wait for the output
//   register to be free.
//   After reset the parser awaits a header; the history holds no data and
//   needs no clearing pass. When the receiver stalls, the output register
//   holds its word and the sequencer waits; no byte is lost.
// ---------------------------------------------------------------------------
module refpack_lz_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 131072
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic [0:0]   in_tuser,   // [0] first_of_stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata,  // [63:0] bytes_0_7, [127:64] bytes_8_15,
                                   // [191:128] bytes_16_23, [255:192] bytes_24_31,
                                   // [261:256] byte_count, [263:262] zero
  output logic         out_tlast,  // last_of_run
  output logic [1:0]   out_tuser   // [0] stream_done, [1] bad_reference
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_PUT,
    S_END
  } state_t;

  state_t            state_r, state_nxt;
  logic [23:0]       produced_r, produced_nxt;
  logic [3:0]        hpos_r, hpos_nxt;
  logic [31:0]       slen_r, slen_nxt;
  logic [23:0]       dsize_r, dsize_nxt;
  logic [31:0]       consumed_r, consumed_nxt;
  rlz_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]        b0_r, b0_nxt;
  logic [15:0]       tail_r, tail_nxt;
  logic [6:0]        lit_r, lit_nxt;
  logic [10:0]       plen_r, plen_nxt;
  logic [17:0]       pdist_r, pdist_nxt;
  logic              halted_r, halted_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [17:0]       dist_r, dist_nxt;
  logic [10:0]       left_r, left_nxt;
  logic              is_copy_r, is_copy_nxt;
  logic              zero_r, zero_nxt;
  logic [7:0]        lbyte_r, lbyte_nxt;
  logic              bad_r, bad_nxt;
  logic              done_r, done_nxt;

  // Step decode results.
  logic              acc;
  logic              a_put;
  logic              a_run;
  logic              a_bad;
  logic              a_done;
  logic [23:0]       a_prod1;
  logic [AW-1:0]     a_wp1;
  logic [AW-1:0]     a_src;

  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_rdata;
  logic [7:0]        put_val;
  rlz_pkg::pk_ctrl_t pk_ctrl;
  rlz_pkg::pk_stat_t pk_stat;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  // Parsing of one accepted byte: header, command bytes and literals.
  always_comb begin
    logic [7:0]  b;
    logic [3:0]  hp;
    logic [31:0] sl;
    logic [23:0] ds;
    logic [31:0] cs;
    logic [23:0] pr;
    logic [AW-1:0] wpb;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [AW:0] wpe;
    logic [AW:0] dse;
    rlz_pkg::phase_t ph;
    b   = in_tdata;
    hp  = in_tuser[0] ? 4'd0 : hpos_r;
    sl  = in_tuser[0] ? 32'd0 : slen_r;
    ds  = in_tuser[0] ? 24'd0 : dsize_r;
    cs  = in_tuser[0] ? 32'd0 : consumed_r;
    pr  = in_tuser[0] ? 24'd0 : produced_r;
    wpb = in_tuser[0] ? '0 : wp_r;
    ph  = in_tuser[0] ? rlz_pkg::PH_CMD : phase_r;
    c1  = '0;
    c2  = '0;
    c3  = '0;
    wpe = '0;
    dse = '0;
    hpos_nxt     = hp;
    slen_nxt     = sl;
    dsize_nxt    = ds;
    consumed_nxt = cs;
    phase_nxt    = ph;
    b0_nxt       = b0_r;
    tail_nxt     = tail_r;
    lit_nxt      = in_tuser[0] ? 7'd0 : lit_r;
    plen_nxt     = in_tuser[0] ? 11'd0 : plen_r;
    pdist_nxt    = in_tuser[0] ? 18'd0 : pdist_r;
    a_put        = 1'b0;
    a_run        = 1'b0;
    a_bad        = 1'b0;
    a_done       = 1'b1;
    if (!(halted_r && !in_tuser[0])) begin
      if (cs != rlz_pkg::CONSUMED_MAX) begin
        consumed_nxt = cs + 32'd1;
      end
      if (hp < rlz_pkg::HDR_LEN) begin
        // Header: stream length, two ignored bytes, output size.
        if (hp < rlz_pkg::HDR_LEN_END) begin
          slen_nxt = {sl[23:0], b};
        end else if (hp >= rlz_pkg::HDR_SIZE_BEG) begin
          dsize_nxt = {ds[15:0], b};
        end
        hpos_nxt = hp + 4'd1;
      end else begin
        unique case (ph)
          rlz_pkg::PH_CMD: begin
            if (b >= rlz_pkg::CMD_LIT_SHORT) begin
              lit_nxt   = {5'd0, 2'(b - rlz_pkg::CMD_LIT_SHORT)};
              plen_nxt  = '0;
              phase_nxt = (b[1:0] != 2'd0) ? rlz_pkg::PH_LIT : rlz_pkg::PH_CMD;
            end else if (b >= rlz_pkg::CMD_LIT_LONG) begin
              lit_nxt   = {5'(b[4:0] + 5'd1), 2'b00};
              plen_nxt  = '0;
              phase_nxt = rlz_pkg::PH_LIT;
            end else begin
              b0_nxt    = b;
              phase_nxt = (b < rlz_pkg::CMD_FORM_TWO) ? rlz_pkg::PH_ONE :
                          (b < rlz_pkg::CMD_FORM_FOUR) ? rlz_pkg::PH_TWO :
                          rlz_pkg::PH_THREE;
            end
          end
          rlz_pkg::PH_ONE, rlz_pkg::PH_TWO, rlz_pkg::PH_THREE: begin
            tail_nxt = {tail_r[7:0], b};
            if (ph != rlz_pkg::PH_ONE) begin
              phase_nxt = rlz_pkg::phase_t'(ph - 3'd1);
            end else begin
              // Last command byte: decode the reference.
              if (b0_r < rlz_pkg::CMD_FORM_TWO) begin
                c1        = b;
                pdist_nxt = 18'({b0_r[6:5], c1}) + 18'd1;
                lit_nxt   = {5'd0, b0_r[1:0]};
                plen_nxt  = 11'(b0_r[4:2]) + 11'd3;
              end else if (b0_r < rlz_pkg::CMD_FORM_FOUR) begin
                c1        = tail_r[7:0];
                c2        = b;
                lit_nxt   = {5'd0, c1[7:6]};
                pdist_nxt = 18'({c1[5:0], c2}) + 18'd1;
                plen_nxt  = 11'(b0_r[5:0]) + 11'd4;
              end else begin
                c1        = tail_r[15:8];
                c2        = tail_r[7:0];
                c3        = b;
                lit_nxt   = {5'd0, b0_r[1:0]};
                plen_nxt  = {1'b0, b0_r[3:2], c3} + rlz_pkg::FAR_LEN_BIAS;
                pdist_nxt = 18'({b0_r[4], c1, c2}) + 18'd1;
              end
              if (lit_nxt != 7'd0) begin
                phase_nxt = rlz_pkg::PH_LIT;
              end else begin
                a_run     = 1'b1;
                phase_nxt = rlz_pkg::PH_CMD;
              end
            end
          end
          rlz_pkg::PH_LIT: begin
            a_put = 1'b1;
            if (lit_nxt != 7'd0) begin
              lit_nxt = lit_nxt - 7'd1;
            end
            if (lit_nxt == 7'd0) begin
              a_run     = (plen_nxt != 11'd0);
              phase_nxt = rlz_pkg::PH_CMD;
            end
          end
          default: begin
            phase_nxt = rlz_pkg::PH_CMD;
          end
        endcase
      end
    end
    // Literal byte is stored only below the output size.
    a_put   = a_put && (pr < ds);
    a_prod1 = pr + 24'(a_put);
    a_bad   = a_run && (a_prod1 < {6'd0, pdist_nxt});
    // Halt check at a command boundary, counting the whole copy.
    if (!(halted_r && !in_tuser[0])) begin
      a_done = (hpos_nxt >= rlz_pkg::HDR_LEN) && (phase_nxt == rlz_pkg::PH_CMD) &&
               (({1'b0, consumed_nxt} >= ({1'b0, slen_nxt} + 33'd4)) ||
                (a_prod1 >= dsize_nxt) ||
                (a_run && (({1'b0, a_prod1} + 25'(plen_nxt)) >= {1'b0, dsize_nxt})));
    end
    if (a_run) begin
      plen_nxt = '0;
    end
    // Copy source pointer, wrapped into the history.
    a_wp1 = wpb;
    if (a_put) begin
      a_wp1 = (wpb == AW'(HISTORY_DEPTH - 1)) ? '0 : wpb + AW'(1);
    end
    wpe = {1'b0, a_wp1};
    dse = (AW + 1)'(pdist_nxt);
    if (wpe >= dse) begin
      a_src = AW'(wpe - dse);
    end else begin
      a_src = AW'(wpe + (AW + 1)'(HISTORY_DEPTH) - dse);
    end
  end

  assign put_val = is_copy_r ? (zero_r ? 8'd0 : mem_rdata) : lbyte_r;

  // Sequencer: literal store, copy loop and result flush.
  always_comb begin
    state_nxt    = state_r;
    produced_nxt = produced_r;
    wp_nxt       = wp_r;
    src_nxt      = src_r;
    dist_nxt     = dist_r;
    left_nxt     = left_r;
    is_copy_nxt  = is_copy_r;
    zero_nxt     = zero_r;
    lbyte_nxt    = lbyte_r;
    bad_nxt      = bad_r;
    done_nxt     = done_r;
    halted_nxt   = halted_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    pk_ctrl      = '0;
    pk_ctrl.bad  = bad_r;
    pk_ctrl.done = done_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          produced_nxt = in_tuser[0] ? 24'd0 : produced_r;
          wp_nxt       = in_tuser[0] ? '0 : wp_r;
          src_nxt      = a_src;
          dist_nxt     = pdist_nxt;
          left_nxt     = a_run ? plen_r_run() : 11'd0;
          is_copy_nxt  = 1'b0;
          zero_nxt     = 1'b0;
          lbyte_nxt    = in_tdata;
          bad_nxt      = a_bad;
          done_nxt     = a_done;
          halted_nxt   = a_done;
          state_nxt    = a_put ? S_PUT : S_RD;
        end
      end
      S_RD: begin
        if (left_r == 11'd0 || produced_r >= dsize_r) begin
          state_nxt = S_END;
        end else begin
          is_copy_nxt = 1'b1;
          zero_nxt    = produced_r < {6'd0, dist_r};
          mem_re      = !(produced_r < {6'd0, dist_r});
          state_nxt   = S_PUT;
        end
      end
      S_PUT: begin
        if (pk_stat.full) begin
          if (pk_stat.out_free) begin
            pk_ctrl.flush = 1'b1;
          end
        end else begin
          pk_ctrl.push = 1'b1;
          mem_we       = 1'b1;
          produced_nxt = produced_r + 24'd1;
          wp_nxt       = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
          if (is_copy_r) begin
            left_nxt = left_r - 11'd1;
            src_nxt  = (src_r == AW'(HISTORY_DEPTH - 1)) ? '0 : src_r + AW'(1);
          end
          state_nxt = S_RD;
        end
      end
      S_END: begin
        if (pk_stat.out_free) begin
          pk_ctrl.flush = 1'b1;
          pk_ctrl.last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Copy length of the reference started by this byte.
  function automatic logic [10:0] plen_r_run();
    logic [10:0] len;
    len = in_tuser[0] ? 11'd0 : plen_r;
    if (phase_r == rlz_pkg::PH_ONE || phase_r == rlz_pkg::PH_TWO ||
        phase_r == rlz_pkg::PH_THREE) begin
      len = decode_len();
    end
    return len;
  endfunction

  // Copy length of a command completed by the current byte.
  function automatic logic [10:0] decode_len();
    logic [10:0] len;
    if (b0_r < rlz_pkg::CMD_FORM_TWO) begin
      len = 11'(b0_r[4:2]) + 11'd3;
    end else if (b0_r < rlz_pkg::CMD_FORM_FOUR) begin
      len = 11'(b0_r[5:0]) + 11'd4;
    end else begin
      len = {1'b0, b0_r[3:2], in_tdata} + rlz_pkg::FAR_LEN_BIAS;
    end
    return len;
  endfunction

  // State and registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      produced_r <= '0;
      hpos_r     <= '0;
      slen_r     <= '0;
      dsize_r    <= '0;
      consumed_r <= '0;
      phase_r    <= rlz_pkg::PH_CMD;
      lit_r      <= '0;
      plen_r     <= '0;
      pdist_r    <= '0;
      halted_r   <= 1'b0;
      wp_r       <= '0;
      left_r     <= '0;
      is_copy_r  <= 1'b0;
      zero_r     <= 1'b0;
      bad_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      produced_r <= produced_nxt;
      wp_r       <= wp_nxt;
      left_r     <= left_nxt;
      is_copy_r  <= is_copy_nxt;
      zero_r     <= zero_nxt;
      bad_r      <= bad_nxt;
      done_r     <= done_nxt;
      halted_r   <= halted_nxt;
      if (acc) begin
        hpos_r     <= hpos_nxt;
        slen_r     <= slen_nxt;
        dsize_r    <= dsize_nxt;
        consumed_r <= consumed_nxt;
        phase_r    <= phase_nxt;
        lit_r      <= lit_nxt;
        plen_r     <= plen_nxt;
        pdist_r    <= pdist_nxt;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    dist_r  <= dist_nxt;
    lbyte_r <= lbyte_nxt;
    if (acc) begin
      b0_r   <= b0_nxt;
      tail_r <= tail_nxt;
    end
  end

  rlz_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (put_val),
    .re    (mem_re),
    .raddr (src_r),
    .rdata (mem_rdata)
  );

  rlz_packer u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (pk_ctrl),
    .push_byte  (put_val),
    .stat       (pk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // A result word never claims more than 32 bytes.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[261:256] <= 6'd32))
    else $error("result byte count above 32");

  // Output never runs past the declared size.
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    produced_r <= dsize_r)
    else $error("produced count beyond declared size");

  // After a byte is taken, the next waits until the step is finished.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a step is in progress");

  // A byte is pushed only while the gathering word has room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    pk_ctrl.push |-> !pk_stat.full)
    else $error("push into a full result word");
`endif

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the RefPack LZ decompressor
// Feeds compressed streams, mostly well-formed with random content, and
// checks every output word against a behavioural decoder kept in the bench.
// ---------------------------------------------------------------------------
module testbench;

  // One output word as the decoder predicts it.
  typedef struct packed {
    logic [255:0] data;
    logic [5:0]   cnt;
    logic         last;
    logic         done;
    logic         bad;
  } res_word_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [263:0] out_tdata;
  logic         out_tlast;
  logic [1:0]   out_tuser;

  refpack_lz_decompressor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // Clock with a period of 12.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder state mirrored in the bench.
  logic [7:0]  hist [0:131071];
  logic [23:0] prod_cnt;
  logic [3:0]  hdr_pos;
  logic [31:0] strm_len;
  logic [23:0] decl_size;
  logic [31:0] cons_cnt;
  rlz_pkg::phase_t phase;
  logic [31:0] cmd_bytes;
  logic [6:0]  lit_left;
  logic [10:0] copy_len;
  logic [17:0] copy_dist;
  logic        halted;

  logic [7:0]  step_bytes [$];
  logic        step_bad;

  res_word_t   expected_words [$];
  logic [8:0]  pending_bytes [$];   // [8] first_of_stream, [7:0] byte
  int          mismatches;
  logic        all_queued;
  logic        hold_start;
  logic        hold_off;

  task automatic clear_decoder();
    prod_cnt = '0; hdr_pos = '0; strm_len = '0; decl_size = '0; cons_cnt = '0;
    phase = rlz_pkg::PH_CMD; cmd_bytes = '0; lit_left = '0; copy_len = '0;
    copy_dist = '0; halted = 1'b0;
  endtask

  task automatic emit_byte(input logic [7:0] v);
    if (prod_cnt < decl_size) begin
      step_bytes.push_back(v);
      hist[prod_cnt[16:0]] = v;
      prod_cnt = prod_cnt + 24'd1;
    end
  endtask

  task automatic run_copy();
    logic [7:0] v;
    if ({14'd0, copy_dist} > {8'd0, prod_cnt}) step_bad = 1'b1;
    for (int i = 0; i < copy_len; i++) begin
      if (prod_cnt >= decl_size) break;
      v = 8'h00;
      if ({8'd0, prod_cnt} >= {14'd0, copy_dist})
        v = hist[17'(prod_cnt - 24'(copy_dist))];
      emit_byte(v);
    end
    copy_len = '0;
  endtask

  task automatic decode_cmd();
    logic [7:0] b0, b1, b2, b3;
    b0 = cmd_bytes[31:24]; b1 = cmd_bytes[23:16];
    b2 = cmd_bytes[15:8];  b3 = cmd_bytes[7:0];
    if (b0 < rlz_pkg::CMD_FORM_TWO) begin
      copy_dist = 18'(b1) + 18'(b0[6:5]) * 18'd256 + 18'd1;
      lit_left  = 7'(b0[1:0]);
      copy_len  = 11'(b0[4:2]) + 11'd3;
    end else if (b0 < rlz_pkg::CMD_FORM_FOUR) begin
      lit_left  = 7'(b1[7:6]);
      copy_dist = 18'(b1[5:0]) * 18'd256 + 18'(b2) + 18'd1;
      copy_len  = 11'(b0[5:0]) + 11'd4;
    end else begin
      lit_left  = 7'(b0[1:0]);
      copy_len  = 11'(b0[3:2]) * 11'd256 + 11'(b3) + rlz_pkg::FAR_LEN_BIAS;
      copy_dist = 18'(b0[4]) * 18'h10000 + 18'(b1) * 18'd256 + 18'(b2) + 18'd1;
    end
    if (lit_left != 0) phase = rlz_pkg::PH_LIT;
    else begin
      run_copy();
      phase = rlz_pkg::PH_CMD;
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [1:0] total;
    logic [1:0] k;
    if (hdr_pos < rlz_pkg::HDR_LEN) begin
      if (hdr_pos < rlz_pkg::HDR_LEN_END) strm_len = {strm_len[23:0], b};
      else if (hdr_pos >= rlz_pkg::HDR_SIZE_BEG) decl_size = {decl_size[15:0], b};
      hdr_pos = hdr_pos + 4'd1;
    end else if (phase == rlz_pkg::PH_CMD) begin
      if (b >= rlz_pkg::CMD_LIT_SHORT) begin
        lit_left = 7'(b - rlz_pkg::CMD_LIT_SHORT);
        copy_len = '0;
        phase = (lit_left != 0) ? rlz_pkg::PH_LIT : rlz_pkg::PH_CMD;
      end else if (b >= rlz_pkg::CMD_LIT_LONG) begin
        lit_left = (7'(b[4:0] & rlz_pkg::LIT_LONG_MASK) + 7'd1) * 7'd4;
        copy_len = '0;
        phase = rlz_pkg::PH_LIT;
      end else begin
        cmd_bytes = {b, 24'd0};
        phase = (b < rlz_pkg::CMD_FORM_TWO) ? rlz_pkg::PH_ONE :
                (b < rlz_pkg::CMD_FORM_FOUR) ? rlz_pkg::PH_TWO : rlz_pkg::PH_THREE;
      end
    end else if (phase != rlz_pkg::PH_LIT) begin
      total = (cmd_bytes[31:24] < rlz_pkg::CMD_FORM_TWO) ? 2'd1 :
              (cmd_bytes[31:24] < rlz_pkg::CMD_FORM_FOUR) ? 2'd2 : 2'd3;
      k = total - 2'(phase) + 2'd1;
      cmd_bytes = cmd_bytes | ({24'd0, b} << (24 - 8 * k));
      phase = rlz_pkg::phase_t'(phase - 3'd1);
      if (phase == rlz_pkg::PH_CMD) decode_cmd();
    end else begin
      emit_byte(b);
      if (lit_left != 0) lit_left = lit_left - 7'd1;
      if (lit_left == 0) begin
        if (copy_len != 0) run_copy();
        phase = rlz_pkg::PH_CMD;
      end
    end
  endtask

  // Work out the output words that one input byte causes.
  task automatic predict_words(input logic first, input logic [7:0] b);
    int nres, cnt;
    res_word_t w;
    step_bytes.delete();
    step_bad = 1'b0;
    if (first) clear_decoder();
    if (!halted) begin
      if (cons_cnt != rlz_pkg::CONSUMED_MAX) cons_cnt = cons_cnt + 32'd1;
      take_byte(b);
      if (hdr_pos >= rlz_pkg::HDR_LEN && phase == rlz_pkg::PH_CMD)
        if ({1'b0, cons_cnt} >= {1'b0, strm_len} + 33'd4 || prod_cnt >= decl_size)
          halted = 1'b1;
    end
    nres = (step_bytes.size() + 31) / 32;
    if (nres == 0) nres = 1;
    for (int r = 0; r < nres; r++) begin
      cnt = step_bytes.size() - r * 32;
      if (cnt > 32) cnt = 32;
      if (cnt < 0) cnt = 0;
      w = '0;
      for (int i = 0; i < cnt; i++) w.data[8 * i +: 8] = step_bytes[r * 32 + i];
      w.cnt = 6'(cnt);
      w.last = (r + 1 == nres);
      w.done = halted;
      w.bad = step_bad;
      expected_words.push_back(w);
    end
  endtask

  // Random gap: mostly short, now and then long.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Input driver.
  int in_gap;
  logic [8:0] cur_word;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_words(in_tuser[0], in_tdata);
        void'(pending_bytes.pop_front());
        in_gap = gap_len();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        cur_word = pending_bytes[0];
        in_tvalid <= 1'b1;
        in_tdata <= cur_word[7:0];
        in_tuser <= cur_word[8];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stalls.
  int out_gap;
  res_word_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.data = out_tdata[255:0];
        got.cnt  = out_tdata[261:256];
        got.last = out_tlast;
        got.done = out_tuser[0];
        got.bad  = out_tuser[1];
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want || out_tdata[263:262] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"word mismatch: expected data %h cnt %0d last %b done %b bad %b,",
                        " got data %h cnt %0d last %b done %b bad %b"},
                       want.data, want.cnt, want.last, want.done, want.bad,
                       got.data, got.cnt, got.last, got.done, got.bad);
          end
        end
        out_gap = gap_len();
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  initial begin
    wait (hold_start);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // Stimulus building helpers.
  task automatic queue_byte(input logic first, input logic [7:0] b);
    pending_bytes.push_back({first, b});
  endtask

  task automatic queue_header(input logic [31:0] len, input logic [23:0] size);
    queue_byte(1'b1, len[31:24]); queue_byte(1'b0, len[23:16]);
    queue_byte(1'b0, len[15:8]);  queue_byte(1'b0, len[7:0]);
    queue_byte(1'b0, 8'($urandom)); queue_byte(1'b0, 8'($urandom));
    queue_byte(1'b0, size[23:16]); queue_byte(1'b0, size[15:8]);
    queue_byte(1'b0, size[7:0]);
  endtask

  // A well-formed stream of random commands; references stay inside the
  // bytes already produced unless bad references are asked for.
  task automatic queue_stream(input int ncmd, input logic allow_bad);
    logic [7:0] body [$];
    int made, nlit, back_dist, len, sel;
    made = 0;
    for (int c = 0; c < ncmd; c++) begin
      sel = $urandom_range(0, 5);
      if (made < 4 && !allow_bad) sel = sel % 2;
      nlit = $urandom_range(0, 3);
      if (sel == 0) begin
        body.push_back(8'hFC + 8'(nlit));
      end else if (sel == 1) begin
        len = $urandom_range(0, 3);
        body.push_back(rlz_pkg::CMD_LIT_LONG + 8'(len));
        nlit = (len + 1) * 4;
      end else begin
        back_dist = allow_bad ? $urandom_range(1, made + 40) : $urandom_range(1, made);
        if (back_dist > 1024) back_dist = $urandom_range(1, 1024);
        if (sel == 2 && back_dist <= 1024) begin
          len = $urandom_range(0, 7);
          body.push_back(8'(((back_dist - 1) >> 8) << 5 | len << 2 | nlit));
          body.push_back(8'(back_dist - 1));
          made += len + 3;
        end else if (sel == 3) begin
          len = $urandom_range(0, 63);
          body.push_back(8'h80 | 8'(len));
          body.push_back(8'(nlit << 6 | ((back_dist - 1) >> 8)));
          body.push_back(8'(back_dist - 1));
          made += len + 4;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) :
                $urandom_range(0, 40);
          body.push_back(8'hC0 | 8'(((len >> 8) & 3) << 2 | nlit));
          body.push_back(8'((back_dist - 1) >> 8));
          body.push_back(8'(back_dist - 1));
          body.push_back(8'(len));
          made += len + 5;
        end
      end
      for (int i = 0; i < nlit; i++) body.push_back(8'($urandom));
      made += nlit;
    end
    queue_header(32'(body.size() + 5), 24'($urandom_range(made / 2, made + 20)));
    foreach (body[i]) queue_byte(1'b0, body[i]);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    mismatches = 0;
    all_queued = 1'b0;
    hold_start = 1'b0;
    hold_off = 1'b0;
    clear_decoder();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every command form, a bad reference, an overlapping copy,
    // extreme bytes and a halt at the end of the declared stream length.
    queue_header(32'd25, 24'd40);
    queue_byte(1'b0, 8'hFF); queue_byte(1'b0, 8'h00); queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, 8'hAA);
    queue_byte(1'b0, 8'h1D); queue_byte(1'b0, 8'h00); queue_byte(1'b0, 8'h55);
    queue_byte(1'b0, 8'h81); queue_byte(1'b0, 8'h00); queue_byte(1'b0, 8'h05);
    queue_byte(1'b0, 8'hC0); queue_byte(1'b0, 8'h00); queue_byte(1'b0, 8'h40);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'hFC);
    queue_byte(1'b0, 8'hE0); queue_byte(1'b0, 8'h01); queue_byte(1'b0, 8'h02);
    queue_byte(1'b0, 8'h03); queue_byte(1'b0, 8'h04);
    queue_byte(1'b0, 8'h12); // ignored once halted
    // Longest far reference with three literals, then a long literal run.
    queue_header(32'hFFFF_FFFF, 24'hFFFFFF);
    queue_byte(1'b0, 8'hDF); queue_byte(1'b0, 8'hFF); queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, 8'hFF);
    for (int i = 0; i < 3; i++) queue_byte(1'b0, 8'($urandom));
    queue_byte(1'b0, 8'hE3);
    for (int i = 0; i < 16; i++) queue_byte(1'b0, 8'($urandom));

    // Random streams, with a long receiver hold-off partway.
    for (int s = 0; s < 2; s++) begin
      queue_stream($urandom_range(3, 6), $urandom_range(0, 3) == 0);
      if (s == 0) begin
        while (pending_bytes.size() > 20) @(posedge clk);
        hold_start = 1'b1;
      end
      if ($urandom_range(0, 2) == 0)
        for (int i = 0; i < 6; i++) queue_byte($urandom_range(0, 9) == 0, 8'($urandom));
    end
    all_queued = 1'b1;
  end

  // End of run once all is sent and every expected word has arrived.
  initial begin
    wait (all_queued);
    while (pending_bytes.size() != 0 || expected_words.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("[refpack_lz_decompressor] OK");
    else
      $display("[refpack_lz_decompressor] ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #30000000;
    $display("[refpack_lz_decompressor] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/rlz_pkg.sv
design/rlz_hist_mem.sv
design/rlz_packer.sv
design/refpack_lz_decompressor.sv
sim/testbench.sv
